FILE: sv/rfid_stream_cipher_48bit_macros.svh
// assertion helpers shared by the cipher rtl
`ifndef RFID_STREAM_CIPHER_48BIT_MACROS_SVH
`define RFID_STREAM_CIPHER_48BIT_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define RSC48_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define RSC48_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rsc48_pkg.sv
package rsc48_pkg;

  // filter tables
  localparam logic [15:0] FILT_A = 16'h2C79;
  localparam logic [15:0] FILT_B = 16'h6671;
  localparam logic [31:0] FILT_C = 32'h7907287B;

  localparam int unsigned STATE_W = 48;
  localparam int unsigned KEY_W   = 48;
  localparam int unsigned SER_W   = 32;
  localparam int unsigned IV_W    = 32;
  localparam int unsigned CNT_W   = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd8;

  // seeding runs in four rounds of eight steps
  localparam logic [1:0] ROUND_FIRST_BUSY = 2'd1;
  localparam logic [1:0] ROUND_MID        = 2'd2;
  localparam logic [1:0] ROUND_LAST       = 2'd3;

  typedef enum logic {
    CMD_INIT  = 1'b0,
    CMD_CRYPT = 1'b1
  } cmd_t;

  // register indexes on the config port
  localparam logic REG_KEY    = 1'b0;
  localparam logic REG_SERIAL = 1'b1;

  typedef struct packed {
    logic              is_init;
    logic [IV_W-1:0]   iv;
    logic [7:0]        data;
    logic [CNT_W-1:0]  cnt;
  } rsc48_item_t;

  function automatic logic filter20(input logic [STATE_W-1:0] s);
    logic [4:0] sel;
    sel[0] = FILT_A[{s[5],  s[4],  s[2],  s[1]}];
    sel[1] = FILT_B[{s[14], s[13], s[11], s[7]}];
    sel[2] = FILT_B[{s[25], s[22], s[20], s[16]}];
    sel[3] = FILT_B[{s[32], s[30], s[28], s[27]}];
    sel[4] = FILT_A[{s[45], s[43], s[42], s[33]}];
    return FILT_C[sel];
  endfunction

  function automatic logic [STATE_W-1:0] lfsr_step(input logic [STATE_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[6] ^ s[7] ^ s[8] ^ s[16] ^ s[22] ^ s[23]
       ^ s[26] ^ s[30] ^ s[41] ^ s[42] ^ s[43] ^ s[46] ^ s[47];
    return {fb, s[STATE_W-1:1]};
  endfunction

  // eight seeding steps: shift, then new msb = filter ^ iv bit ^ key bit
  function automatic logic [STATE_W-1:0] init_round(input logic [STATE_W-1:0] s_in,
                                                    input logic [7:0] ivb,
                                                    input logic [7:0] kb);
    logic [STATE_W-1:0] s;
    s = s_in;
    for (int j = 0; j < 8; j++) begin
      s = {1'b0, s[STATE_W-1:1]};
      s[STATE_W-1] = filter20(s) ^ ivb[j] ^ kb[j];
    end
    return s;
  endfunction

endpackage

FILE: sv/rsc48_front.sv
module rsc48_front
  import rsc48_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [IV_W-1:0]   in_init_vector,
  input  logic [7:0]        in_data_in,
  input  logic [CNT_W-1:0]  in_bit_count,
  output logic              q_valid,
  output rsc48_item_t       q_item,
  input  logic              q_pop
);

  rsc48_item_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  rsc48_item_t item;
  logic        push;

  // classify and clamp the bit count
  always_comb begin
    item.is_init = (cmd_t'(in_command) == CMD_INIT);
    item.iv      = in_init_vector;
    item.data    = in_data_in;
    item.cnt     = (in_bit_count > CNT_MAX) ? CNT_MAX : in_bit_count;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: sv/rsc48_back.sv
module rsc48_back
  import rsc48_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KEY_W-1:0]  key,
  input  logic [SER_W-1:0]  serial,
  input  logic              q_valid,
  input  rsc48_item_t       q_item,
  output logic              q_pop,
  output logic              seeding,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data_out
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEED = 2'b10
  } st_t;

  st_t                st_r, st_nxt;
  logic [STATE_W-1:0] state_r, state_nxt;
  logic [1:0]         round_r, round_nxt;
  logic [31:8]        iv_hi_r, iv_hi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_free;
  logic [STATE_W-1:0] crypt_s;
  logic [7:0]         crypt_d;
  logic [STATE_W-1:0] seed_s;
  logic [STATE_W-1:0] round_s;
  logic [7:0]         ivb;
  logic [7:0]         kb;

  assign out_free = !out_valid_r || out_ready;

  // up to eight lfsr clocks, keystream bits msb first
  always_comb begin
    crypt_s = state_r;
    crypt_d = q_item.data;
    for (int i = 0; i < 8; i++) begin
      if (CNT_W'(i) < q_item.cnt) begin
        crypt_s = lfsr_step(crypt_s);
        crypt_d[3'(7 - i)] = crypt_d[3'(7 - i)] ^ filter20(crypt_s);
      end
    end
  end

  assign seed_s = init_round({key[15:0], serial}, q_item.iv[7:0], key[23:16]);

  always_comb begin
    case (round_r)
      ROUND_FIRST_BUSY: begin
        ivb = iv_hi_r[15:8];
        kb  = key[31:24];
      end
      ROUND_MID: begin
        ivb = iv_hi_r[23:16];
        kb  = key[39:32];
      end
      default: begin
        ivb = iv_hi_r[31:24];
        kb  = key[47:40];
      end
    endcase
  end

  assign round_s = init_round(state_r, ivb, kb);

  always_comb begin
    st_nxt        = st_r;
    state_nxt     = state_r;
    round_nxt     = round_r;
    iv_hi_nxt     = iv_hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && (q_item.is_init || out_free)) begin
          q_pop = 1'b1;
          if (q_item.is_init) begin
            state_nxt = seed_s;
            iv_hi_nxt = q_item.iv[31:8];
            round_nxt = ROUND_FIRST_BUSY;
            st_nxt    = ST_SEED;
          end else begin
            state_nxt     = crypt_s;
            out_data_nxt  = crypt_d;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SEED: begin
        if (round_r != ROUND_LAST) begin
          state_nxt = round_s;
          round_nxt = round_r + 2'd1;
        end else if (out_free) begin
          state_nxt     = round_s;
          out_data_nxt  = 8'd0;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      state_r     <= '0;
      round_r     <= ROUND_FIRST_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iv_hi_r    <= iv_hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign seeding      = (st_r == ST_SEED);
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

FILE: sv/rfid_stream_cipher_48bit.sv
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | in_valid / in_ready  | in_command, in_init_vector, in_data_in,
//           |                      | in_bit_count
// result    | out_valid/out_ready  | out_data_out
// config    | psel/penable/pready  | paddr, pwrite, pwdata, prdata (key @0, sn @8)
//
// crypt word: up to eight lfsr clocks unrolled in the cipher engine
// init word: the 32 seeding steps run eight per cycle, the last eight only
// once the result register is free; a two-word queue sits between the
// classifier and the engine; while a result waits on out_ready, the engine
// still starts an init word but holds crypt words back
// rst_n is synchronous: clears the shift register, key and serial number
`include "rfid_stream_cipher_48bit_macros.svh"

module rfid_stream_cipher_48bit
  import rsc48_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [IV_W-1:0]   in_init_vector,
  input  logic [7:0]        in_data_in,
  input  logic [CNT_W-1:0]  in_bit_count,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data_out,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [KEY_W-1:0] key_r;
  logic [SER_W-1:0] serial_r;
  logic             cfg_wr;
  logic             q_valid;
  logic             q_pop;
  rsc48_item_t      q_item;
  logic             seeding;

  // register write on the access phase; index is address bit 3
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      serial_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY:    key_r    <= pwdata[KEY_W-1:0];
        REG_SERIAL: serial_r <= pwdata[SER_W-1:0];
        default:    ;
      endcase
    end
  end

  // read back; off-word addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (paddr[3])
        REG_KEY:    prdata = {16'd0, key_r};
        REG_SERIAL: prdata = {32'd0, serial_r};
        default:    prdata = '0;
      endcase
    end
  end

  // classifier and word queue
  rsc48_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_init_vector (in_init_vector),
    .in_data_in     (in_data_in),
    .in_bit_count   (in_bit_count),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // cipher engine with result register
  rsc48_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .key          (key_r),
    .serial       (serial_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .seeding      (seeding),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out)
  );

  // engine only pulls words that are there
  `RSC48_ASSERT_NOW(a_pop_has_word, q_pop, q_valid, "pop from empty queue")
  // no new word while seeding rounds are running
  `RSC48_ASSERT_NOW(a_no_pop_seeding, seeding, !q_pop, "pop during seeding")
  // an init word pulled from the queue starts the seeding rounds
  `RSC48_ASSERT_NEXT(a_init_starts_seed, q_pop && q_item.is_init, seeding,
                     "init word did not start seeding")
  // seeding either continues or ends with a result
  `RSC48_ASSERT_NEXT(a_seed_ends_in_result, seeding, seeding || out_valid,
                     "seeding ended without a result")

endmodule

FILE: tb/sv/rsc48_result_checker.sv
module rsc48_result_checker
  import rsc48_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_init_vector,
  input  logic [7:0]  in_data_in,
  input  logic [3:0]  in_bit_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_data_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int          mismatches,
  output int          bytes_pending,
  output int          bytes_checked,
  output int          init_words,
  output int          crypt_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0]  KEY_ADDR      = {REG_KEY, 3'b000};
  localparam logic [3:0]  SERIAL_ADDR   = {REG_SERIAL, 3'b000};
  localparam logic [15:0] NIB_TABLE_A   = 16'h2C79;
  localparam logic [15:0] NIB_TABLE_B   = 16'h6671;
  localparam logic [31:0] SEL_TABLE_C   = 32'h7907287B;
  // taps 0,2,3,6,7,8,16,22,23,26,30,41,42,43,46,47
  localparam logic [47:0] FEEDBACK_TAPS = 48'hCE00_44C1_01CD;
  localparam int          MAX_BITS      = 8;

  logic [47:0] shift_reg;
  logic [47:0] key_reg;
  logic [31:0] serial_reg;
  logic [7:0]  expected_bytes[$];
  logic [7:0]  byte_val;
  logic [7:0]  want;
  int          steps;

  function automatic logic [3:0] pick4(input logic [47:0] s, input int a, b, c, d);
    return {s[d], s[c], s[b], s[a]};
  endfunction

  function automatic logic keystream_bit(input logic [47:0] s);
    logic [4:0] sel;
    sel[0] = NIB_TABLE_A[pick4(s, 1, 2, 4, 5)];
    sel[1] = NIB_TABLE_B[pick4(s, 7, 11, 13, 14)];
    sel[2] = NIB_TABLE_B[pick4(s, 16, 20, 22, 25)];
    sel[3] = NIB_TABLE_B[pick4(s, 27, 28, 30, 32)];
    sel[4] = NIB_TABLE_A[pick4(s, 33, 42, 43, 45)];
    return SEL_TABLE_C[sel];
  endfunction

  function automatic logic [47:0] seeded_state(input logic [47:0] key,
                                               input logic [31:0] serial,
                                               input logic [31:0] iv);
    logic [47:0] x;
    x = {key[15:0], serial};
    for (int i = 0; i < 32; i++) begin
      x = x >> 1;
      x[47] = keystream_bit(x) ^ iv[i] ^ key[i+16];
    end
    return x;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shift_reg = '0;
      key_reg = '0;
      serial_reg = '0;
      expected_bytes.delete();
      mismatches = 0;
      bytes_pending = 0;
      bytes_checked = 0;
      init_words = 0;
      crypt_words = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          KEY_ADDR:    key_reg = pwdata[47:0];
          SERIAL_ADDR: serial_reg = pwdata[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_INIT) begin
          shift_reg = seeded_state(key_reg, serial_reg, in_init_vector);
          expected_bytes.push_back(8'h00);
          init_words++;
        end else begin
          steps = (in_bit_count > MAX_BITS) ? MAX_BITS : int'(in_bit_count);
          byte_val = in_data_in;
          for (int i = 0; i < steps; i++) begin
            shift_reg = {^(shift_reg & FEEDBACK_TAPS), shift_reg[47:1]};
            byte_val[7-i] ^= keystream_bit(shift_reg);
          end
          expected_bytes.push_back(byte_val);
          crypt_words++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word data_out=%02h at %0t", out_data_out, $realtime);
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want !== out_data_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("data_out mismatch on result %0d: expected %02h got %02h",
                       bytes_checked, want, out_data_out);
          end
        end
      end
      bytes_pending = expected_bytes.size();
    end
  end

endmodule

FILE: tb/sv/rfid_stream_cipher_48bit_test.sv
module rfid_stream_cipher_48bit_test;
  import rsc48_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // register map: 48-bit key forces the 8-byte stride
  localparam logic [3:0] KEY_ADDR    = {REG_KEY, 3'b000};
  localparam logic [3:0] SERIAL_ADDR = {REG_SERIAL, 3'b000};
  localparam int PHASE_WORDS = 617;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_INIT;
  logic [31:0] in_init_vector = '0;
  logic [7:0]  in_data_in = '0;
  logic [3:0]  in_bit_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int mismatches, bytes_pending, bytes_checked, init_words, crypt_words;

  // idling knobs, percent of cycles spent idle on each side
  int sender_idle_pct = 29;
  int receiver_idle_pct = 59;
  // long receiver hold-off, requested by the stimulus and counted by the receiver
  bit hold_request = 1'b0;
  int hold_left = 0;

  always #6 clk = ~clk;

  rfid_stream_cipher_48bit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_init_vector(in_init_vector), .in_data_in(in_data_in), .in_bit_count(in_bit_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_out(out_data_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rsc48_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_init_vector(in_init_vector), .in_data_in(in_data_in), .in_bit_count(in_bit_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_out(out_data_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .bytes_pending(bytes_pending),
    .bytes_checked(bytes_checked), .init_words(init_words), .crypt_words(crypt_words)
  );

  // receiver side: random back-pressure, or a long hold when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // offer one word, with an optional random gap first; returns at the
  // edge where the word is taken, valid still high
  task automatic send_word(input cmd_t cmd, input logic [31:0] iv,
                           input logic [7:0] data, input logic [3:0] cnt);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_init_vector <= iv;
    in_data_in <= data;
    in_bit_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result word has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // give the engine some slack before the next phase
    repeat (8) @(posedge clk);
  endtask

  // setup phase, access phase, then the bus goes quiet
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // mostly full bytes, some partial, a few zero and oversized counts
  function automatic logic [3:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 4'd8;
    if (r < 85) return 4'($urandom_range(7, 1));
    if (r < 90) return 4'd0;
    return 4'($urandom_range(15, 9));
  endfunction

  // init followed by a run of crypt words; now and then the init is
  // skipped so the keystream just carries on from the last session
  task automatic run_sessions(input int words);
    int sent;
    int run_len;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(7) != 0) begin
        send_word(CMD_INIT, $urandom, 8'($urandom), 4'($urandom));
        sent++;
      end
      run_len = $urandom_range(12, 1);
      for (int k = 0; k < run_len && sent < words; k++) begin
        send_word(CMD_CRYPT, $urandom, 8'($urandom), pick_count());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset value: crypt on the all-zero state before any init
    send_word(CMD_CRYPT, 32'h0, 8'hFF, 4'd8);
    send_word(CMD_CRYPT, 32'hFFFF_FFFF, 8'hA5, 4'd0);   // zero count passes data through
    send_word(CMD_INIT, 32'h0, 8'hFF, 4'hF);            // init ignores data and count
    send_word(CMD_CRYPT, 32'h0, 8'h00, 4'd8);
    send_word(CMD_CRYPT, 32'h0, 8'hFF, 4'd15);          // oversized count saturates
    send_word(CMD_CRYPT, 32'h0, 8'h5A, 4'd1);
    send_word(CMD_CRYPT, 32'h0, 8'hC3, 4'd4);
    send_word(CMD_INIT, 32'hFFFF_FFFF, 8'h00, 4'd0);
    send_word(CMD_CRYPT, 32'hFFFF_FFFF, 8'h00, 4'd9);   // crypt ignores the iv
    send_word(CMD_CRYPT, 32'h0, 8'hFF, 4'd7);
    drain_results();

    // all-ones key and serial, upper bus bits set too
    write_reg(KEY_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(SERIAL_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_INIT, 32'h0, 8'h00, 4'd8);
    send_word(CMD_CRYPT, 32'h0, 8'h00, 4'd8);
    send_word(CMD_CRYPT, 32'h0, 8'hFF, 4'd3);
    send_word(CMD_INIT, 32'hFFFF_FFFF, 8'hFF, 4'd8);
    send_word(CMD_CRYPT, 32'h0, 8'h55, 4'd8);
    send_word(CMD_CRYPT, 32'h0, 8'hAA, 4'd12);
    send_word(CMD_CRYPT, 32'h0, 8'h00, 4'd0);
    send_word(CMD_CRYPT, 32'h0, 8'h80, 4'd2);
    drain_results();

    // random key and serial, sender light, receiver heavy idling
    write_reg(KEY_ADDR, {$urandom, $urandom});
    write_reg(SERIAL_ADDR, {$urandom, $urandom});
    run_sessions(PHASE_WORDS);
    drain_results();

    // zero key, random serial, idling swapped
    sender_idle_pct = 59;
    receiver_idle_pct = 29;
    write_reg(KEY_ADDR, 64'h0);
    write_reg(SERIAL_ADDR, {$urandom, $urandom});
    run_sessions(PHASE_WORDS);
    drain_results();

    // random key, zero serial, full rate; receiver stalls long at the start
    // so the queue fills and in_ready drops while words keep coming
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_reg(KEY_ADDR, {$urandom, $urandom});
    write_reg(SERIAL_ADDR, 64'h0);
    hold_request = 1'b1;
    run_sessions(PHASE_WORDS);
    drain_results();

    $display("run covered %0d words (%0d init, %0d crypt), %0d result words checked",
             init_words + crypt_words, init_words, crypt_words, bytes_checked);
    $display("over five key/serial settings, three idling mixes and one long receiver stall");
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
